[hdl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue cell chain.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_DEPTH = 16;

   localparam int DATA_WIDTH   = 32;
   localparam int OPCODE_WIDTH = 3;
   localparam int STATUS_WIDTH = 2;
   localparam int POS_WIDTH    = 5;

   localparam int REQ_TDATA_WIDTH = 40;
   localparam int RSP_TDATA_WIDTH = 40;

   // request opcodes
   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_LIST       = 3'd4;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR      = 3'd5;

   // response status
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   // what every cell does in a cycle
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT_R,   // take left neighbor, head takes the pushed value
      CELL_SHIFT_L,   // take right neighbor
      CELL_ROT_L,     // shift left, back cell takes the head value
      CELL_WRITE      // the cell at the count position takes the value
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic signed [DATA_WIDTH-1:0] value;
   } cell_cmd_type;

endpackage

[hdl/deq_cell.sv]
// ----------------------------------------------------------------------------
// deq_cell
// One entry of the queue chain. Entries sit front to back from cell 0.
// ----------------------------------------------------------------------------
module deq_cell import deq_pkg::*; #(
   parameter int CELL_INDEX  = 0,
   parameter int COUNT_WIDTH = 5
) (
   input  logic                         clock,
   input  cell_cmd_type                 cmd,
   input  logic [COUNT_WIDTH-1:0]       count,
   input  logic signed [DATA_WIDTH-1:0] left_data,
   input  logic signed [DATA_WIDTH-1:0] right_data,
   input  logic signed [DATA_WIDTH-1:0] head_data,
   output logic signed [DATA_WIDTH-1:0] data
);

   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [DATA_WIDTH-1:0] data_in;
   logic                         at_count;
   logic                         at_back;

   assign at_count = (count == COUNT_WIDTH'(CELL_INDEX));
   assign at_back  = (count == COUNT_WIDTH'(CELL_INDEX + 1));

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_HOLD:    data_in = data_ff;
         CELL_SHIFT_R: data_in = left_data;
         CELL_SHIFT_L: data_in = right_data;
         CELL_ROT_L:   data_in = at_back ? head_data : right_data;
         CELL_WRITE:   data_in = at_count ? cmd.value : data_ff;
         default:      data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[hdl/deq_ctrl.sv]
// ----------------------------------------------------------------------------
// deq_ctrl
// Opcode sequencer: entry count, rotation and list steps, response register.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; #(
   parameter int DEPTH       = DEQ_DEPTH,
   parameter int COUNT_WIDTH = $clog2(DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [OPCODE_WIDTH-1:0]      req_opcode,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [STATUS_WIDTH-1:0]      rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_value,
   output logic [POS_WIDTH-1:0]         rsp_position,
   output logic                         rsp_last,
   input  logic signed [DATA_WIDTH-1:0] head_data,
   output cell_cmd_type                 cell_cmd,
   output logic [COUNT_WIDTH-1:0]       count
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_LIST
   } state_type;

   state_type                    state_ff, state_in;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;
   logic [COUNT_WIDTH-1:0]       step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_WIDTH-1:0]         rsp_position_ff, rsp_position_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   req_fire;
   logic                   is_full;
   logic                   is_empty;
   logic                   list_last;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic [31:0]            pos_wide;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign is_full    = (count_ff == COUNT_WIDTH'(DEPTH));
   assign is_empty   = (count_ff == '0);
   assign count_dec  = COUNT_WIDTH'(count_ff - 1'b1);
   assign list_last  = (step_ff == count_dec);
   assign pos_wide   = 32'(step_ff) + 32'd1;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_position_in = rsp_position_ff;
      rsp_last_in     = rsp_last_ff;
      cell_cmd.op     = CELL_HOLD;
      cell_cmd.value  = req_value;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_OK;
               rsp_value_in    = '0;
               rsp_position_in = '0;
               rsp_last_in     = 1'b1;
               case (req_opcode)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        cell_cmd.op = (req_opcode == OP_PUSH_FRONT) ? CELL_SHIFT_R
                                                                    : CELL_WRITE;
                        count_in    = COUNT_WIDTH'(count_ff + 1'b1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_value_in = head_data;
                        cell_cmd.op  = CELL_SHIFT_L;
                        count_in     = count_dec;
                     end
                  end
                  OP_POP_BACK, OP_LIST: begin
                     if (is_empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        // result comes from the rotate/list sequence instead
                        rsp_valid_in = 1'b0;
                        if (req_opcode == OP_POP_BACK) begin
                           state_in = ST_ROTATE;
                           step_in  = count_dec;
                        end else begin
                           state_in = ST_LIST;
                           step_in  = '0;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     // unused opcodes are dropped without a beat
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end

         ST_ROTATE: begin
            // bring the back entry to the head, then pop it from there
            if (step_ff != '0) begin
               cell_cmd.op = CELL_ROT_L;
               step_in     = COUNT_WIDTH'(step_ff - 1'b1);
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_OK;
               rsp_value_in    = head_data;
               rsp_position_in = '0;
               rsp_last_in     = 1'b1;
               cell_cmd.op     = CELL_SHIFT_L;
               count_in        = count_dec;
               state_in        = ST_IDLE;
            end
         end

         ST_LIST: begin
            // a full lap of rotations leaves the order as it was
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = ST_OK;
               rsp_value_in    = head_data;
               rsp_position_in = pos_wide[POS_WIDTH-1:0];
               rsp_last_in     = list_last;
               cell_cmd.op     = CELL_ROT_L;
               step_in         = COUNT_WIDTH'(step_ff + 1'b1);
               if (list_last) begin
                  state_in = ST_IDLE;
                  step_in  = '0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_position_ff <= rsp_position_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;
   assign count        = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("entry count above depth");

   a_busy_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE || state_ff == ST_LIST) |-> !is_empty)
      else $error("rotate or list sequence on an empty queue");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_full &&
       (req_opcode == OP_PUSH_FRONT || req_opcode == OP_PUSH_BACK))
      |=> count_ff == COUNT_WIDTH'($past(count_ff) + 1'b1))
      else $error("push did not add an entry");

   a_list_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST && $past(state_ff) == ST_LIST) |-> $stable(count_ff))
      else $error("entry count moved during list");

   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST && out_free && list_last) |=> state_ff == ST_IDLE)
      else $error("list did not return to idle after the last beat");

endmodule

[hdl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Entries sit front to back from cell 0, and only cell 0 is ever read. Push
// front, push back, pop front and clear each give one response beat. Pop back
// rotates the chain left one cell per cycle until the back entry reaches the
// head, then pops it once the response register is free. List emits one beat
// per entry as the chain rotates a full lap, holding while a beat waits; a
// list or pop of an empty queue gives one empty beat. One request is worked
// on at a time, and a new one is taken while the previous response beat is
// being taken. Opcodes 6 and 7 are dropped with no response.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = DEQ_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,   // opcode[2:0], value[34:3], zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,   // status[1:0], result_value[33:2],
                                                   // position[38:34], zero
   output logic                       rsp_tlast
);

   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
   cell_cmd_type                 cell_cmd;
   logic [COUNT_WIDTH-1:0]       count;
   logic [STATUS_WIDTH-1:0]      rsp_status;
   logic signed [DATA_WIDTH-1:0] rsp_value;
   logic [POS_WIDTH-1:0]         rsp_position;

   deq_ctrl #(
      .DEPTH       (DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_opcode   (req_tdata[OPCODE_WIDTH-1:0]),
      .req_value    (req_tdata[OPCODE_WIDTH+DATA_WIDTH-1:OPCODE_WIDTH]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_status   (rsp_status),
      .rsp_value    (rsp_value),
      .rsp_position (rsp_position),
      .rsp_last     (rsp_tlast),
      .head_data    (cell_data[0]),
      .cell_cmd     (cell_cmd),
      .count        (count)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] left_data;
      logic signed [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = cell_cmd.value;
      end else begin : g_body
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      deq_cell #(
         .CELL_INDEX  (i),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .count      (count),
         .left_data  (left_data),
         .right_data (right_data),
         .head_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   assign rsp_tdata = {
      {(RSP_TDATA_WIDTH - STATUS_WIDTH - DATA_WIDTH - POS_WIDTH){1'b0}},
      rsp_position, rsp_value, rsp_status
   };

endmodule
